FILE: rtl/core/xsf_pkg.sv
// shared constants and request codes for the xor sprite framebuffer
package xsf_pkg;

    localparam int SCREEN_WIDTH_DEF  = 64;
    localparam int SCREEN_HEIGHT_DEF = 32;
    localparam int SPRITE_BITS       = 8;

    localparam int REQ_W    = 2;
    localparam int POS_X_W  = 6;
    localparam int POS_Y_W  = 5;
    localparam int OFFSET_W = 4;
    localparam int PIXELS_W = 64;

    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DRAW  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

endpackage

FILE: rtl/core/xsf_req_if.sv
// request channel carrying one draw, clear or read transaction
interface xsf_req_if;

    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [5:0] pos_x;
    logic [4:0] pos_y;
    logic [3:0] row_offset;
    logic [7:0] sprite_byte;
    logic       first_row;
    logic       last_row;

    modport source
    (
        output valid, req_type, pos_x, pos_y, row_offset, sprite_byte, first_row, last_row,
        input  ready
    );

    modport sink
    (
        input  valid, req_type, pos_x, pos_y, row_offset, sprite_byte, first_row, last_row,
        output ready
    );

endinterface

FILE: rtl/core/xsf_rsp_if.sv
// response channel carrying collision flags and one screen row
interface xsf_rsp_if;

    logic        valid;
    logic        ready;
    logic        row_collision;
    logic        sprite_collision;
    logic        sprite_done;
    logic [63:0] row_pixels;

    modport source
    (
        output valid, row_collision, sprite_collision, sprite_done, row_pixels,
        input  ready
    );

    modport sink
    (
        input  valid, row_collision, sprite_collision, sprite_done, row_pixels,
        output ready
    );

endinterface

FILE: rtl/core/xor_sprite_framebuffer.sv
// one-bit framebuffer with xor sprite row drawing, clear and row read-back
// a request is captured into the request registers, then its result is registered in the response register
// a new request is taken only once the previous one has done its row read-modify-write on the single-port store
// the response register lets the next request enter while a response waits
// reset: all rows read as zero at once (per-row valid bits), collision flag cleared
module xor_sprite_framebuffer
    import xsf_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    xsf_req_if.sink     req,
    xsf_rsp_if.source   rsp
);

    localparam int ROW_W    = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
    localparam int COL_W    = $clog2(SCREEN_WIDTH);
    localparam int SUM_Y_W  = POS_Y_W + 1;
    localparam int SUM_X_W  = POS_X_W + 1;
    localparam int ROW_TBL  = 1 << SUM_Y_W;
    localparam int COL_TBL  = 1 << SUM_X_W;

    typedef enum logic [0:0]
    {
        S_IDLE,
        S_EXEC
    } state_t;

    // wrap tables, filled at elaboration
    logic [ROW_W-1:0] row_tbl [ROW_TBL];
    logic [COL_W-1:0] pos_tbl [COL_TBL];

    genvar k;
    generate
        for (k = 0; k < ROW_TBL; k++)
        begin : g_row_tbl
            assign row_tbl[k] = ROW_W'(k % SCREEN_HEIGHT);
        end
        for (k = 0; k < COL_TBL; k++)
        begin : g_pos_tbl
            assign pos_tbl[k] = COL_W'(SCREEN_WIDTH - 1 - (k % SCREEN_WIDTH));
        end
    endgenerate

    logic [SCREEN_WIDTH-1:0]  mem [SCREEN_HEIGHT];
    logic [SCREEN_WIDTH-1:0]  rd_data_reg;
    logic                     rd_valid_reg;

    state_t                   state_reg, state_next;
    logic [REQ_W-1:0]         req_type_reg, req_type_next;
    logic                     first_reg, first_next;
    logic                     last_reg, last_next;
    logic [ROW_W-1:0]         row_addr_reg, row_addr_next;
    logic [SCREEN_WIDTH-1:0]  mask_reg, mask_next;
    logic [SCREEN_HEIGHT-1:0] row_valid_reg, row_valid_next;
    logic                     sticky_reg, sticky_next;

    logic                     rsp_valid_reg, rsp_valid_next;
    logic                     row_col_reg, row_col_next;
    logic                     done_reg, done_next;
    logic [PIXELS_W-1:0]      pixels_reg, pixels_next;

    logic                     accept;
    logic                     exec_go;
    logic                     mem_we;
    logic [SCREEN_WIDTH-1:0]  old_row;
    logic [SCREEN_WIDTH-1:0]  new_row;
    logic [SUM_Y_W-1:0]       y_sum;
    logic [SUM_X_W-1:0]       x_sum;
    logic                     hit;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign exec_go   = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp.ready);

    assign old_row = rd_valid_reg ? rd_data_reg : '0;
    assign new_row = old_row ^ mask_reg;
    assign hit     = |(old_row & mask_reg);
    assign mem_we  = exec_go && (req_type_reg == REQ_DRAW);

    assign rsp.valid            = rsp_valid_reg;
    assign rsp.row_collision    = row_col_reg;
    assign rsp.sprite_collision = sticky_reg;
    assign rsp.sprite_done      = done_reg;
    assign rsp.row_pixels       = pixels_reg;

    always_comb
    begin
        state_next     = state_reg;
        req_type_next  = req_type_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        row_addr_next  = row_addr_reg;
        mask_next      = mask_reg;
        row_valid_next = row_valid_reg;
        sticky_next    = sticky_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        row_col_next   = row_col_reg;
        done_next      = done_reg;
        pixels_next    = pixels_reg;
        y_sum          = '0;
        x_sum          = '0;

        if (accept)
        begin
            state_next    = S_EXEC;
            req_type_next = req.req_type;
            first_next    = req.first_row;
            last_next     = req.last_row;
            if (req.req_type == REQ_DRAW)
            begin
                y_sum = SUM_Y_W'(req.pos_y) + SUM_Y_W'(req.row_offset);
            end
            else
            begin
                y_sum = SUM_Y_W'(req.pos_y);
            end
            row_addr_next = row_tbl[y_sum];
            mask_next     = '0;
            for (int i = 0; i < SPRITE_BITS; i++)
            begin
                x_sum = SUM_X_W'(req.pos_x) + SUM_X_W'(i);
                if (req.sprite_byte[SPRITE_BITS-1-i])
                begin
                    mask_next[pos_tbl[x_sum]] = 1'b1;
                end
            end
        end

        if (exec_go)
        begin
            state_next     = S_IDLE;
            rsp_valid_next = 1'b1;
            row_col_next   = 1'b0;
            done_next      = 1'b0;
            pixels_next    = '0;
            case (req_type_reg)
                REQ_CLEAR:
                begin
                    row_valid_next = '0;
                end
                REQ_DRAW:
                begin
                    row_valid_next[row_addr_reg] = 1'b1;
                    sticky_next  = (sticky_reg && !first_reg) || hit;
                    row_col_next = hit;
                    done_next    = last_reg;
                    pixels_next  = PIXELS_W'(new_row);
                end
                REQ_READ:
                begin
                    pixels_next = PIXELS_W'(old_row);
                end
                default:
                begin
                    pixels_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            req_type_reg  <= REQ_CLEAR;
            first_reg     <= 1'b0;
            last_reg      <= 1'b0;
            row_addr_reg  <= '0;
            mask_reg      <= '0;
            row_valid_reg <= '0;
            sticky_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
            row_col_reg   <= 1'b0;
            done_reg      <= 1'b0;
            pixels_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            req_type_reg  <= req_type_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
            row_addr_reg  <= row_addr_next;
            mask_reg      <= mask_next;
            row_valid_reg <= row_valid_next;
            sticky_reg    <= sticky_next;
            rsp_valid_reg <= rsp_valid_next;
            row_col_reg   <= row_col_next;
            done_reg      <= done_next;
            pixels_reg    <= pixels_next;
        end
    end

    // row store, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[row_addr_reg] <= new_row;
        end
        if (accept)
        begin
            rd_data_reg  <= mem[row_addr_next];
            rd_valid_reg <= row_valid_reg[row_addr_next];
        end
    end

endmodule

FILE: sim/tb_xor_sprite_framebuffer.sv
// self-checking testbench for the xor sprite framebuffer, directed table then random sprite traffic
`timescale 1ns / 100ps

module tb;

    import xsf_pkg::*;

    localparam int SCR_W        = SCREEN_WIDTH_DEF;
    localparam int SCR_H        = SCREEN_HEIGHT_DEF;
    localparam int PHASE_ITEMS  = 575;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed
    {
        logic [REQ_W-1:0]       req_type;
        logic [POS_X_W-1:0]     pos_x;
        logic [POS_Y_W-1:0]     pos_y;
        logic [OFFSET_W-1:0]    row_offset;
        logic [SPRITE_BITS-1:0] sprite_byte;
        logic                   first_row;
        logic                   last_row;
    } fb_request_t;

    typedef struct packed
    {
        logic                row_collision;
        logic                sprite_collision;
        logic                sprite_done;
        logic [PIXELS_W-1:0] row_pixels;
    } fb_response_t;

    typedef struct packed
    {
        fb_request_t  req;
        logic         fixed;
        fb_response_t rsp;
    } directed_row_t;

    localparam fb_response_t RSP_ZERO = '0;

    // fixed rows carry the response read straight off the spec
    localparam directed_row_t DIRECTED [25] = '{
        '{'{REQ_READ,   6'd0,  5'd0,  4'd0,  8'h00, 1'b0, 1'b0}, 1'b1, RSP_ZERO},
        '{'{REQ_READ,   6'd63, 5'd31, 4'd15, 8'hFF, 1'b1, 1'b1}, 1'b1, RSP_ZERO},
        '{'{REQ_DRAW,   6'd0,  5'd0,  4'd0,  8'hFF, 1'b1, 1'b1}, 1'b1,
            '{1'b0, 1'b0, 1'b1, 64'hFF00_0000_0000_0000}},
        '{'{REQ_DRAW,   6'd0,  5'd0,  4'd0,  8'hFF, 1'b1, 1'b1}, 1'b1,
            '{1'b1, 1'b1, 1'b1, 64'h0}},
        '{'{REQ_DRAW,   6'd63, 5'd31, 4'd15, 8'h81, 1'b1, 1'b0}, 1'b1,
            '{1'b0, 1'b0, 1'b0, 64'h0200_0000_0000_0001}},
        '{'{REQ_READ,   6'd0,  5'd14, 4'd0,  8'h00, 1'b0, 1'b0}, 1'b0, RSP_ZERO},
        '{'{REQ_DRAW,   6'd60, 5'd14, 4'd0,  8'hF0, 1'b0, 1'b1}, 1'b0, RSP_ZERO},
        '{'{REQ_DRAW,   6'd32, 5'd5,  4'd3,  8'h00, 1'b1, 1'b1}, 1'b1,
            '{1'b0, 1'b0, 1'b1, 64'h0}},
        '{'{REQ_DRAW,   6'd56, 5'd0,  4'd15, 8'hAA, 1'b1, 1'b0}, 1'b0, RSP_ZERO},
        '{'{REQ_DRAW,   6'd57, 5'd16, 4'd15, 8'h55, 1'b0, 1'b0}, 1'b0, RSP_ZERO},
        '{'{REQ_DRAW,   6'd57, 5'd16, 4'd15, 8'h55, 1'b0, 1'b1}, 1'b0, RSP_ZERO},
        '{'{REQ_READ,   6'd0,  5'd31, 4'd7,  8'h00, 1'b0, 1'b0}, 1'b0, RSP_ZERO},
        '{'{REQ_READ,   6'd0,  5'd15, 4'd0,  8'h00, 1'b0, 1'b0}, 1'b0, RSP_ZERO},
        '{'{REQ_UNUSED, 6'd63, 5'd31, 4'd15, 8'hFF, 1'b1, 1'b1}, 1'b0, RSP_ZERO},
        '{'{REQ_CLEAR,  6'd63, 5'd31, 4'd15, 8'hFF, 1'b1, 1'b1}, 1'b0, RSP_ZERO},
        '{'{REQ_READ,   6'd0,  5'd15, 4'd0,  8'h00, 1'b0, 1'b0}, 1'b0, RSP_ZERO},
        '{'{REQ_READ,   6'd0,  5'd0,  4'd0,  8'h00, 1'b0, 1'b0}, 1'b0, RSP_ZERO},
        '{'{REQ_DRAW,   6'd7,  5'd3,  4'd2,  8'hC3, 1'b1, 1'b0}, 1'b0, RSP_ZERO},
        '{'{REQ_DRAW,   6'd7,  5'd3,  4'd2,  8'h3C, 1'b0, 1'b0}, 1'b0, RSP_ZERO},
        '{'{REQ_DRAW,   6'd7,  5'd3,  4'd2,  8'hFF, 1'b0, 1'b1}, 1'b0, RSP_ZERO},
        '{'{REQ_UNUSED, 6'd0,  5'd0,  4'd0,  8'h00, 1'b0, 1'b0}, 1'b0, RSP_ZERO},
        '{'{REQ_CLEAR,  6'd0,  5'd0,  4'd0,  8'h00, 1'b0, 1'b0}, 1'b0, RSP_ZERO},
        '{'{REQ_DRAW,   6'd0,  5'd0,  4'd0,  8'h80, 1'b0, 1'b1}, 1'b0, RSP_ZERO},
        '{'{REQ_READ,   6'd0,  5'd0,  4'd0,  8'h00, 1'b0, 1'b0}, 1'b0, RSP_ZERO},
        '{'{REQ_READ,   6'd9,  5'd31, 4'd1,  8'h5A, 1'b1, 1'b0}, 1'b0, RSP_ZERO}
    };

    logic clk;
    logic rst_n;

    int send_idle_pct;
    int recv_stall_pct;
    int mismatch_count;
    int cycle_count;

    logic [PIXELS_W-1:0] screen_model [SCR_H];
    logic                collision_flag;
    fb_response_t        pending_rsp [$];

    xsf_req_if req_if ();
    xsf_rsp_if rsp_if ();

    xor_sprite_framebuffer u_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic draw_model(input fb_request_t r, output fb_response_t res);
        int                  row;
        int                  col;
        logic [PIXELS_W-1:0] mask;
        logic [PIXELS_W-1:0] old_row;
        res = '0;
        case (r.req_type)
            REQ_CLEAR:
            begin
                foreach (screen_model[i])
                    screen_model[i] = '0;
            end
            REQ_DRAW:
            begin
                row  = (int'(r.pos_y) + int'(r.row_offset)) % SCR_H;
                mask = '0;
                for (int i = 0; i < SPRITE_BITS; i++)
                begin
                    if (r.sprite_byte[SPRITE_BITS-1-i])
                    begin
                        col = (int'(r.pos_x) + i) % SCR_W;
                        mask[SCR_W-1-col] = 1'b1;
                    end
                end
                old_row = screen_model[row];
                screen_model[row] = old_row ^ mask;
                if (r.first_row)
                    collision_flag = 1'b0;
                res.row_collision = |(old_row & mask);
                if (res.row_collision)
                    collision_flag = 1'b1;
                res.sprite_done = r.last_row;
                res.row_pixels  = screen_model[row];
            end
            REQ_READ:
                res.row_pixels = screen_model[int'(r.pos_y) % SCR_H];
            default:
                ;
        endcase
        res.sprite_collision = collision_flag;
    endtask

    function automatic fb_request_t random_request();
        logic [31:0] bits;
        bits = $urandom;
        return bits[$bits(fb_request_t)-1:0];
    endfunction

    task automatic send_request(input fb_request_t r, input logic fixed,
                                input fb_response_t fixed_rsp);
        fb_response_t predicted;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.req_type    <= r.req_type;
        req_if.pos_x       <= r.pos_x;
        req_if.pos_y       <= r.pos_y;
        req_if.row_offset  <= r.row_offset;
        req_if.sprite_byte <= r.sprite_byte;
        req_if.first_row   <= r.first_row;
        req_if.last_row    <= r.last_row;
        do
            @(posedge clk);
        while (req_if.ready !== 1'b1);
        draw_model(r, predicted);
        pending_rsp.push_back(fixed ? fixed_rsp : predicted);
    endtask

    // mostly well-formed sprites, some with broken offsets and flags, plus reads, clears and noise
    task automatic run_random(input int n_items);
        int          sent;
        int          pick;
        int          rows;
        fb_request_t base;
        fb_request_t r;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            base = random_request();
            if (pick < 72)
            begin
                rows = $urandom_range(15, 1);
                for (int i = 0; i < rows; i++)
                begin
                    r             = base;
                    r.req_type    = REQ_DRAW;
                    r.sprite_byte = SPRITE_BITS'($urandom_range(255));
                    if (pick < 62)
                    begin
                        r.row_offset = OFFSET_W'(i);
                        r.first_row  = (i == 0);
                        r.last_row   = (i == rows - 1);
                    end
                    else
                    begin
                        r.row_offset = OFFSET_W'($urandom_range(15));
                        r.first_row  = 1'($urandom_range(1));
                        r.last_row   = 1'($urandom_range(1));
                    end
                    send_request(r, 1'b0, RSP_ZERO);
                end
                sent += rows;
            end
            else
            begin
                r = base;
                if (pick < 88)
                    r.req_type = REQ_READ;
                else if (pick < 92)
                    r.req_type = REQ_CLEAR;
                else if (pick < 95)
                    r.req_type = REQ_UNUSED;
                send_request(r, 1'b0, RSP_ZERO);
                sent++;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(negedge clk)
        rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        fb_response_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: unexpected response transaction, expected none, actual %h", $time,
                         rsp_if.row_pixels);
                mismatch_count++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                check_field("row_collision", 64'(want.row_collision),
                            64'(rsp_if.row_collision));
                check_field("sprite_collision", 64'(want.sprite_collision),
                            64'(rsp_if.sprite_collision));
                check_field("sprite_done", 64'(want.sprite_done), 64'(rsp_if.sprite_done));
                check_field("row_pixels", want.row_pixels, rsp_if.row_pixels);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("xor_sprite_framebuffer regression: fail");
            $finish;
        end
    end

    initial
    begin
        clk                = 1'b0;
        rst_n              = 1'b0;
        send_idle_pct      = 11;
        recv_stall_pct     = 57;
        mismatch_count     = 0;
        cycle_count        = 0;
        collision_flag     = 1'b0;
        req_if.valid       = 1'b0;
        req_if.req_type    = REQ_CLEAR;
        req_if.pos_x       = '0;
        req_if.pos_y       = '0;
        req_if.row_offset  = '0;
        req_if.sprite_byte = '0;
        req_if.first_row   = 1'b0;
        req_if.last_row    = 1'b0;
        rsp_if.ready       = 1'b0;
        foreach (screen_model[i])
            screen_model[i] = '0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i])
            send_request(DIRECTED[i].req, DIRECTED[i].fixed, DIRECTED[i].rsp);
        run_random(PHASE_ITEMS);

        send_idle_pct  = 57;
        recv_stall_pct = 11;
        run_random(PHASE_ITEMS);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(PHASE_ITEMS);

        @(negedge clk);
        req_if.valid <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("xor_sprite_framebuffer regression: pass");
        else
            $display("xor_sprite_framebuffer regression: fail");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/xsf_pkg.sv
rtl/core/xsf_req_if.sv
rtl/core/xsf_rsp_if.sv
rtl/core/xor_sprite_framebuffer.sv
sim/tb_xor_sprite_framebuffer.sv
